/* hw/rtl/mts_pkg.sv */
`default_nettype none

package mts_pkg;

  // Stack size and fixed-point format
  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 8;

  // Matrix geometry: four rows of four 16-bit entries
  localparam int ROWS      = 4;
  localparam int COLS      = 4;
  localparam int ENT_W     = 16;
  localparam int ROW_W     = COLS * ENT_W;
  localparam int ROW_IDX_W = $clog2(ROWS);

  // Storage addressing: one slot of ROWS rows per stored matrix
  localparam int SLOT_W    = $clog2(STACK_DEPTH);
  localparam int ADDR_W    = SLOT_W + ROW_IDX_W;
  localparam int MEM_DEPTH = STACK_DEPTH * ROWS;
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_W   = 5;

  // Sequencer: ROWS reads, then two pipeline stages to drain
  localparam int RUN_LAST  = ROWS + 1;
  localparam int STEP_W    = $clog2(RUN_LAST + 1);

  // Operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [ENT_W-1:0] ONE_Q = ENT_W'(1) << FRAC_BITS;

  typedef logic [ROW_W-1:0] row_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                 load;    // capture request, flags and operand
    logic                 rd_en;   // read one row of the current top
    logic [ROW_IDX_W-1:0] rd_row;
    logic                 commit;  // update stack count
    logic                 xfer;    // move finished result to output register
  } cmd_t;

  function automatic row_t ident_row(input logic [ROW_IDX_W-1:0] r);
    row_t v;
    v = '0;
    v[ENT_W*r +: ENT_W] = ONE_Q;
    return v;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mts_if.sv */
`default_nettype none

interface mts_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  mts_pkg::row_t       in_row0;
  mts_pkg::row_t       in_row1;
  mts_pkg::row_t       in_row2;
  mts_pkg::row_t       in_row3;

  modport source (output valid, op, in_row0, in_row1, in_row2, in_row3, input ready);
  modport sink   (input valid, op, in_row0, in_row1, in_row2, in_row3, output ready);
endinterface

interface mts_out_if;
  logic                          valid;
  logic                          ready;
  mts_pkg::row_t                 top_row0;
  mts_pkg::row_t                 top_row1;
  mts_pkg::row_t                 top_row2;
  mts_pkg::row_t                 top_row3;
  logic [mts_pkg::DEPTH_W-1:0]   depth;
  logic                          was_empty;
  logic                          overflow;

  modport source (output valid, top_row0, top_row1, top_row2, top_row3, depth,
                  was_empty, overflow, input ready);
  modport sink   (input valid, top_row0, top_row1, top_row2, top_row3, depth,
                  was_empty, overflow, output ready);
endinterface

`default_nettype wire

/* hw/rtl/matrix_transform_stack_top.sv */
// Matrix transform stack: bounded stack of 4x4 Q7.8 transform matrices.
// in_ch carries one request per handshake: op (push, pop, peek, clear) and,
// for push, the four rows of the operand matrix, column 0 in the low bits.
// out_ch returns exactly one result per request: four result rows, the
// depth after the request, and the was_empty / overflow flags.
// A push stores (current top, or identity when empty) times the operand,
// rounded half up and saturated to 16 bits; a push into a full stack
// returns the current top with overflow set and leaves the stack alone.
// Timing: a result appears on out_ch once it is handed to the output register,
// and in_ch is ready again in that same cycle. The four top rows are read
// one per cycle from the row store, whose writes of the new top overlap the
// later reads; each row goes through
// sixteen parallel 16x16 multipliers, then an adder/round/saturate stage.
// One request is in flight at a time; none is accepted until the last is handed off.
// Results sit in an output register, so the next request is accepted while
// a result waits; if the receiver stalls, the following result is held
// finished inside the block until the output register is taken.
// Reset (rst_n low, synchronous) empties the stack and drops any result;
// stored rows are not cleared, and a row that has not been rewritten is never used.
`default_nettype none

module matrix_transform_stack_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mts_in_if.sink     in_ch,
  mts_out_if.source  out_ch
);

  mts_pkg::cmd_t cmd;
  logic          in_ready;
  logic          out_valid;

  // sequencer: accept, four row reads, pipeline drain, hand-off
  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // row store, multiply lanes, count and output register
  mts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .op        (in_ch.op),
    .in_row0   (in_ch.in_row0),
    .in_row1   (in_ch.in_row1),
    .in_row2   (in_ch.in_row2),
    .in_row3   (in_ch.in_row3),
    .top_row0  (out_ch.top_row0),
    .top_row1  (out_ch.top_row1),
    .top_row2  (out_ch.top_row2),
    .top_row3  (out_ch.top_row3),
    .depth     (out_ch.depth),
    .was_empty (out_ch.was_empty),
    .overflow  (out_ch.overflow)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // an accepted request starts with a read of row 0 of the top
  a_start_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (cmd.rd_en && (cmd.rd_row == '0)))
    else $error("request accepted without starting the row reads");

  // a refused push never also reports an empty stack
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.was_empty && out_ch.overflow))
    else $error("overflow and was_empty both set");

  // reported depth never exceeds the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (mts_pkg::STACK_DEPTH < 32))
      |-> (out_ch.depth <= mts_pkg::STACK_DEPTH))
    else $error("depth beyond stack size");

  // count update and result hand-off never coincide with a new request
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (cmd.xfer || !in_ch.ready))
    else $error("request accepted before the result was handed off");

endmodule

`default_nettype wire

/* hw/rtl/mts_ctrl.sv */
`default_nettype none

module mts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mts_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [mts_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // no request is taken while reset is held
        in_ready = rst_n;
        if (rst_n && in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.rd_en  = (step_r < mts_pkg::STEP_W'(mts_pkg::ROWS));
        cmd.rd_row = step_r[mts_pkg::ROW_IDX_W-1:0];
        if (step_r == mts_pkg::STEP_W'(mts_pkg::RUN_LAST)) begin
          cmd.commit = 1'b1;
          state_nxt  = S_HOLD;
        end else begin
          step_nxt = step_r + mts_pkg::STEP_W'(1);
        end
      end
      S_HOLD: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.xfer  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mts_dp.sv */
`default_nettype none

module mts_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mts_pkg::cmd_t                 cmd,
  input  wire logic [1:0]                    op,
  input  wire mts_pkg::row_t                 in_row0,
  input  wire mts_pkg::row_t                 in_row1,
  input  wire mts_pkg::row_t                 in_row2,
  input  wire mts_pkg::row_t                 in_row3,
  output mts_pkg::row_t                      top_row0,
  output mts_pkg::row_t                      top_row1,
  output mts_pkg::row_t                      top_row2,
  output mts_pkg::row_t                      top_row3,
  output logic [mts_pkg::DEPTH_W-1:0]        depth,
  output logic                               was_empty,
  output logic                               overflow
);

  localparam logic [1:0] MODE_MUL  = 2'd0;  // product of top and operand
  localparam logic [1:0] MODE_PASS = 2'd1;  // current top (or identity)
  localparam logic [1:0] MODE_ZERO = 2'd2;  // cleared result

  localparam int ACC_W = 2 * mts_pkg::ENT_W + 3;
  localparam logic signed [ACC_W-1:0] RND     = ACC_W'(1) << (mts_pkg::FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

  localparam int CNT_W  = mts_pkg::CNT_W;
  localparam int ENT_W  = mts_pkg::ENT_W;
  localparam int ROWS   = mts_pkg::ROWS;
  localparam int COLS   = mts_pkg::COLS;
  localparam int RIW    = mts_pkg::ROW_IDX_W;

  // request state
  logic [1:0]                 op_r;
  mts_pkg::row_t              b_r [ROWS];
  logic                       empty_r, full_r;
  logic [1:0]                 mode_r;
  logic                       flag_empty_r, flag_ovf_r;
  logic [CNT_W-1:0]           count_r;

  // matrix storage
  mts_pkg::row_t              mem [mts_pkg::MEM_DEPTH];
  mts_pkg::row_t              rdata_r;
  logic [mts_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic                       wr_en;

  // pipeline
  logic                       s1_valid_r, s2_valid_r;
  logic [RIW-1:0]             s1_row_r, s2_row_r;
  mts_pkg::row_t              a_row, pass_r;
  logic signed [ENT_W-1:0]    a_ent [COLS];
  logic signed [ENT_W-1:0]    b_ent [ROWS][COLS];
  logic signed [2*ENT_W-1:0]  prod_nxt [COLS][ROWS];
  logic signed [2*ENT_W-1:0]  prod_r   [COLS][ROWS];
  mts_pkg::row_t              sat_row, res_row;
  mts_pkg::row_t              work_r [ROWS];

  logic [CNT_W+mts_pkg::DEPTH_W-1:0] depth_wide;

  // output register
  mts_pkg::row_t              out_row_r [ROWS];
  logic [mts_pkg::DEPTH_W-1:0] depth_r;
  logic                       was_empty_r, overflow_r;

  assign rd_addr = {mts_pkg::SLOT_W'(count_r - CNT_W'(1)), cmd.rd_row};
  assign wr_addr = {mts_pkg::SLOT_W'(count_r), s2_row_r};
  assign wr_en   = s2_valid_r && (mode_r == MODE_MUL);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= res_row;
    end
  end

  // stage 1: sixteen products of one top row against the operand
  always_comb begin
    a_row = empty_r ? mts_pkg::ident_row(s1_row_r) : rdata_r;
    for (int k = 0; k < COLS; k++) begin
      a_ent[k] = a_row[ENT_W*k +: ENT_W];
      for (int j = 0; j < COLS; j++) begin
        b_ent[k][j] = b_r[k][ENT_W*j +: ENT_W];
      end
    end
    for (int j = 0; j < COLS; j++) begin
      for (int k = 0; k < ROWS; k++) begin
        prod_nxt[j][k] = a_ent[k] * b_ent[k][j];
      end
    end
  end

  // stage 2: sum, round half up, saturate
  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] q;
    sat_row = '0;
    for (int j = 0; j < COLS; j++) begin
      acc = RND;
      for (int k = 0; k < ROWS; k++) begin
        acc = acc + ACC_W'(prod_r[j][k]);
      end
      q = acc >>> mts_pkg::FRAC_BITS;
      if (q > SAT_MAX) begin
        sat_row[ENT_W*j +: ENT_W] = 16'h7fff;
      end else if (q < SAT_MIN) begin
        sat_row[ENT_W*j +: ENT_W] = 16'h8000;
      end else begin
        sat_row[ENT_W*j +: ENT_W] = q[ENT_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (mode_r)
      MODE_MUL:  res_row = sat_row;
      MODE_PASS: res_row = pass_r;
      default:   res_row = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      prod_r <= prod_nxt;
      pass_r <= a_row;
    end
    if (s2_valid_r) begin
      work_r[s2_row_r] <= res_row;
    end
    s1_row_r <= cmd.rd_row;
    s2_row_r <= s1_row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.rd_en;
      s2_valid_r <= s1_valid_r;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= op;
      b_r[0]       <= in_row0;
      b_r[1]       <= in_row1;
      b_r[2]       <= in_row2;
      b_r[3]       <= in_row3;
      empty_r      <= (count_r == '0);
      full_r       <= (count_r >= CNT_W'(mts_pkg::STACK_DEPTH));
      flag_empty_r <= ((op == mts_pkg::OP_POP) || (op == mts_pkg::OP_PEEK))
                      && (count_r == '0);
      flag_ovf_r   <= (op == mts_pkg::OP_PUSH)
                      && (count_r >= CNT_W'(mts_pkg::STACK_DEPTH));
      if (op == mts_pkg::OP_CLEAR) begin
        mode_r <= MODE_ZERO;
      end else if ((op == mts_pkg::OP_PUSH)
                   && (count_r < CNT_W'(mts_pkg::STACK_DEPTH))) begin
        mode_r <= MODE_MUL;
      end else begin
        mode_r <= MODE_PASS;
      end
    end
  end

  // stack count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      unique case (op_r)
        mts_pkg::OP_PUSH:  if (!full_r)  count_r <= count_r + CNT_W'(1);
        mts_pkg::OP_POP:   if (!empty_r) count_r <= count_r - CNT_W'(1);
        mts_pkg::OP_PEEK:  count_r <= count_r;
        mts_pkg::OP_CLEAR: count_r <= '0;
        default:           count_r <= count_r;
      endcase
    end
  end

  assign depth_wide = (CNT_W + mts_pkg::DEPTH_W)'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.xfer) begin
      out_row_r   <= work_r;
      depth_r     <= depth_wide[mts_pkg::DEPTH_W-1:0];
      was_empty_r <= flag_empty_r;
      overflow_r  <= flag_ovf_r;
    end
  end

  assign top_row0  = out_row_r[0];
  assign top_row1  = out_row_r[1];
  assign top_row2  = out_row_r[2];
  assign top_row3  = out_row_r[3];
  assign depth     = depth_r;
  assign was_empty = was_empty_r;
  assign overflow  = overflow_r;

endmodule

`default_nettype wire
